FILE: rtl/apu_tone_pkg.sv
// Package: shared types, codes and tables for the tone channel block.
package apu_tone_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_FRAME = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic [10:0] PERIOD_MAX = 11'h7FF;

   function automatic logic [7:0] length_lookup(input logic [4:0] idx);
      logic [7:0] r;
      case (idx)
         5'd0: r = 8'd10;   5'd1: r = 8'd254;  5'd2: r = 8'd20;   5'd3: r = 8'd2;
         5'd4: r = 8'd40;   5'd5: r = 8'd4;    5'd6: r = 8'd80;   5'd7: r = 8'd6;
         5'd8: r = 8'd160;  5'd9: r = 8'd8;    5'd10: r = 8'd60;  5'd11: r = 8'd10;
         5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
         5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
         5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
         5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
         5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
      endcase
      return r;
   endfunction

   function automatic logic duty_lookup(input logic [1:0] duty, input logic [2:0] step);
      logic [7:0] pat;
      case (duty)
         2'd0: pat = 8'b0000_0010;
         2'd1: pat = 8'b0000_0110;
         2'd2: pat = 8'b0001_1110;
         default: pat = 8'b1111_1001;
      endcase
      return pat[step];
   endfunction

   // Triangle: descends 15..0 then ascends 0..15
   function automatic logic [3:0] tri_lookup(input logic [4:0] step);
      return step[4] ? step[3:0] : ~step[3:0];
   endfunction

endpackage

FILE: rtl/apu_tone_pulse.sv
// One pulse channel: timer, duty sequencer, envelope, sweep and length counter.
module apu_tone_pulse (
   input  logic       clock,
   input  logic       reset,
   input  logic       second,
   input  logic       wr_r0,
   input  logic       wr_r1,
   input  logic       wr_r2,
   input  logic       wr_r3,
   input  logic [7:0] write_data,
   input  logic       tick,
   input  logic       env_clk,
   input  logic       half_clk,
   output logic [3:0] level
);
   import apu_tone_pkg::*;

   logic [7:0]  r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic [10:0] timer_ff, timer_in, period_ff, period_in;
   logic [2:0]  step_ff, step_in;
   logic [7:0]  length_ff, length_in;
   logic [3:0]  vol_ff, vol_in, ediv_ff, ediv_in, sdiv_ff, sdiv_in;
   logic        estart_ff, estart_in, sreload_ff, sreload_in;
   logic [11:0] tgt;
   logic [10:0] chg;
   logic [3:0]  vol_out;

   always_comb begin
      r0_in = wr_r0 ? write_data : r0_ff;
      r1_in = wr_r1 ? write_data : r1_ff;
      r2_in = wr_r2 ? write_data : r2_ff;
      r3_in = wr_r3 ? write_data : r3_ff;
      timer_in = timer_ff; step_in = step_ff; period_in = period_ff;
      length_in = length_ff; vol_in = vol_ff; ediv_in = ediv_ff;
      sdiv_in = sdiv_ff; estart_in = estart_ff; sreload_in = sreload_ff;
      chg = period_ff >> r1_ff[2:0];
      if (r1_ff[3])
         tgt = {1'b0, period_ff} - {1'b0, chg} - {11'd0, ~second};
      else
         tgt = {1'b0, period_ff} + {1'b0, chg};

      // register side effects
      if (wr_r3) begin
         length_in = length_lookup(write_data[7:3]);
         estart_in = 1'b1;
         period_in = {write_data[2:0], r2_ff};
      end
      if (wr_r2) period_in = {r3_ff[2:0], write_data};
      if (wr_r1) sreload_in = 1'b1;

      // timer tick
      if (tick) begin
         if (timer_ff == 11'd0) begin
            timer_in = period_ff;
            step_in  = step_ff + 3'd1;
         end else begin
            timer_in = timer_ff - 11'd1;
         end
      end

      // envelope
      if (env_clk) begin
         if (estart_ff) begin
            estart_in = 1'b0;
            vol_in = 4'hF;
            ediv_in = r0_ff[3:0];
         end else if (ediv_ff != 4'd0) begin
            ediv_in = ediv_ff - 4'd1;
         end else begin
            ediv_in = r0_ff[3:0];
            if (vol_ff != 4'd0) vol_in = vol_ff - 4'd1;
            else if (r0_ff[5]) vol_in = 4'hF;
         end
         if (r0_ff[4]) vol_in = r0_ff[3:0];
      end

      // length then sweep
      if (half_clk) begin
         if (!r0_ff[5] && length_ff != 8'd0) length_in = length_ff - 8'd1;
         if (sreload_ff) begin
            sdiv_in = {1'b0, r1_ff[6:4]} + 4'd1;
            sreload_in = 1'b0;
         end else if (sdiv_ff != 4'd0) begin
            sdiv_in = sdiv_ff - 4'd1;
         end else begin
            sdiv_in = {1'b0, r1_ff[6:4]} + 4'd1;
            if (r1_ff[7] && r1_ff[2:0] != 3'd0) begin
               if (tgt < 12'd8 || tgt > {1'b0, PERIOD_MAX}) length_in = 8'd0;
               else period_in = tgt[10:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_ff <= 8'h30; r1_ff <= 8'h08; r2_ff <= 8'h00; r3_ff <= 8'h00;
         timer_ff <= '0; step_ff <= '0; period_ff <= '0; length_ff <= '0;
         vol_ff <= '0; ediv_ff <= '0; sdiv_ff <= '0;
         estart_ff <= 1'b1; sreload_ff <= 1'b1;
      end else begin
         r0_ff <= r0_in; r1_ff <= r1_in; r2_ff <= r2_in; r3_ff <= r3_in;
         timer_ff <= timer_in; step_ff <= step_in; period_ff <= period_in;
         length_ff <= length_in; vol_ff <= vol_in; ediv_ff <= ediv_in;
         sdiv_ff <= sdiv_in; estart_ff <= estart_in; sreload_ff <= sreload_in;
      end
   end

   // level uses the advanced step, the current period and length
   assign vol_out = r0_ff[4] ? r0_ff[3:0] : vol_ff;
   assign level = (tick && duty_lookup(r0_ff[7:6], step_in) && period_ff >= 11'd8
                   && length_ff != 8'd0) ? vol_out : 4'd0;
endmodule

FILE: rtl/apu_tone_triangle.sv
// Triangle channel: timer, 32-step sequencer, linear and length counters.
module apu_tone_triangle (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_r0,
   input  logic       wr_r2,
   input  logic       wr_r3,
   input  logic [7:0] write_data,
   input  logic       tick,
   input  logic       quarter_clk,
   input  logic       half_clk,
   output logic [3:0] level
);
   import apu_tone_pkg::*;

   logic [7:0]  r0_ff, r0_in, r2_ff, r2_in, r3_ff, r3_in, length_ff, length_in;
   logic [10:0] timer_ff, timer_in;
   logic [4:0]  step_ff, step_in;
   logic [6:0]  linear_ff, linear_in, lreload_ff, lreload_in;
   logic        rflag_ff, rflag_in, active;

   assign active = linear_ff != 7'd0 && length_ff != 8'd0;

   always_comb begin
      r0_in = wr_r0 ? write_data : r0_ff;
      r2_in = wr_r2 ? write_data : r2_ff;
      r3_in = wr_r3 ? write_data : r3_ff;
      timer_in = timer_ff; step_in = step_ff; linear_in = linear_ff;
      lreload_in = lreload_ff; rflag_in = rflag_ff; length_in = length_ff;
      if (wr_r0) begin
         lreload_in = write_data[6:0];
         rflag_in = 1'b1;
      end
      if (wr_r3) begin
         length_in = length_lookup(write_data[7:3]);
         rflag_in = 1'b1;
      end
      if (tick && active) begin
         if (timer_ff == 11'd0) begin
            timer_in = {r3_ff[2:0], r2_ff};
            step_in = step_ff + 5'd1;
         end else begin
            timer_in = timer_ff - 11'd1;
         end
      end
      if (quarter_clk) begin
         if (rflag_ff) linear_in = lreload_ff;
         else if (linear_ff != 7'd0) linear_in = linear_ff - 7'd1;
         if (!r0_ff[7]) rflag_in = 1'b0;
      end
      if (half_clk && !r0_ff[7] && length_ff != 8'd0) length_in = length_ff - 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_ff <= 8'h80; r2_ff <= '0; r3_ff <= '0; length_ff <= '0;
         timer_ff <= '0; step_ff <= '0; linear_ff <= '0; lreload_ff <= '0;
         rflag_ff <= 1'b0;
      end else begin
         r0_ff <= r0_in; r2_ff <= r2_in; r3_ff <= r3_in; length_ff <= length_in;
         timer_ff <= timer_in; step_ff <= step_in; linear_ff <= linear_in;
         lreload_ff <= lreload_in; rflag_ff <= rflag_in;
      end
   end

   assign level = (tick && active) ? tri_lookup(step_in) : 4'd0;
endmodule

FILE: rtl/console_apu_tone_channels.sv
// Top level: decode, frame sequencer, channel instances and result register.
// One item is taken per clock and its levels appear in the result register on the next
// cycle; a beat waiting in that register does not block a new one while rsp_ready is
// high. Each item is worked in a single pass of combinational logic between the request
// handshake and the result register, so the rate is one item per cycle unless a held result stalls it.
module console_apu_tone_channels (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [4:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_pulse_one_level,
   output logic [3:0] rsp_pulse_two_level,
   output logic [3:0] rsp_triangle_level
);
   import apu_tone_pkg::*;

   logic       go, wr, tick, frame, qclk, hclk, mode5;
   logic [7:0] enable_ff, enable_in, fctl_ff, fctl_in;
   logic [2:0] fcnt_ff, fcnt_in;
   logic       valid_ff;
   logic [3:0] l1_ff, l2_ff, lt_ff, l1, l2, lt;
   logic [7:0] p1_wr, p2_wr;
   logic [3:0] t_wr;

   assign req_ready = !valid_ff || rsp_ready;
   assign go    = req_valid && req_ready;
   assign wr    = go && req_action == ACT_WRITE;
   assign tick  = go && req_action == ACT_TICK;
   assign frame = go && req_action == ACT_FRAME;
   assign mode5 = fctl_ff[7];

   // register decode
   always_comb begin
      p1_wr = '0; p2_wr = '0; t_wr = '0;
      enable_in = enable_ff; fctl_in = fctl_ff;
      if (wr) begin
         unique case (req_reg_offset)
            5'h00: p1_wr[0] = 1'b1;
            5'h01: p1_wr[1] = 1'b1;
            5'h02: p1_wr[2] = 1'b1;
            5'h03: p1_wr[3] = 1'b1;
            5'h04: p2_wr[0] = 1'b1;
            5'h05: p2_wr[1] = 1'b1;
            5'h06: p2_wr[2] = 1'b1;
            5'h07: p2_wr[3] = 1'b1;
            5'h08: t_wr[0] = 1'b1;
            5'h0A: t_wr[2] = 1'b1;
            5'h0B: t_wr[3] = 1'b1;
            5'h15: enable_in = req_write_data;
            5'h17: fctl_in = req_write_data;
            default: ;
         endcase
      end
   end

   // frame sequencer
   always_comb begin
      qclk = 1'b0; hclk = 1'b0; fcnt_in = fcnt_ff;
      if (frame) begin
         if (!mode5) begin
            qclk = 1'b1;
            hclk = fcnt_ff == 3'd1 || fcnt_ff == 3'd3;
            fcnt_in = {1'b0, fcnt_ff[1:0] + 2'd1};
         end else begin
            qclk = fcnt_ff != 3'd3;
            hclk = fcnt_ff == 3'd1 || fcnt_ff == 3'd4;
            fcnt_in = (fcnt_ff >= 3'd4) ? 3'(fcnt_ff - 3'd4) : fcnt_ff + 3'd1;
         end
      end
   end

   apu_tone_pulse u_pulse_one (
      .clock, .reset, .second(1'b0),
      .wr_r0(p1_wr[0]), .wr_r1(p1_wr[1]), .wr_r2(p1_wr[2]), .wr_r3(p1_wr[3]),
      .write_data(req_write_data), .tick(tick && enable_ff[0]),
      .env_clk(qclk), .half_clk(hclk), .level(l1)
   );

   apu_tone_pulse u_pulse_two (
      .clock, .reset, .second(1'b1),
      .wr_r0(p2_wr[0]), .wr_r1(p2_wr[1]), .wr_r2(p2_wr[2]), .wr_r3(p2_wr[3]),
      .write_data(req_write_data), .tick(tick && enable_ff[1]),
      .env_clk(qclk), .half_clk(hclk), .level(l2)
   );

   apu_tone_triangle u_triangle (
      .clock, .reset,
      .wr_r0(t_wr[0]), .wr_r2(t_wr[2]), .wr_r3(t_wr[3]),
      .write_data(req_write_data), .tick(tick && enable_ff[2]),
      .quarter_clk(qclk), .half_clk(hclk), .level(lt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0; fctl_ff <= '0; fcnt_ff <= '0; valid_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in; fctl_ff <= fctl_in; fcnt_ff <= fcnt_in;
         if (req_ready) valid_ff <= req_valid;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (go) begin
         l1_ff <= l1; l2_ff <= l2; lt_ff <= lt;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_pulse_one_level = l1_ff;
   assign rsp_pulse_two_level = l2_ff;
   assign rsp_triangle_level  = lt_ff;
endmodule

FILE: sim/apu_tone_checker.sv
`timescale 1ns / 1ps
// Checker: watches request and result beats, predicts the levels and compares.
module apu_tone_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [4:0]  req_reg_offset,
   input  logic [7:0]  req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_pulse_one_level,
   input  logic [3:0]  rsp_pulse_two_level,
   input  logic [3:0]  rsp_triangle_level,
   output int          fail_count,
   output int          levels_pending,
   output int          levels_seen
);
   import apu_tone_pkg::*;

   typedef struct packed {
      logic [3:0] p1;
      logic [3:0] p2;
      logic [3:0] tri_lvl;
   } level_set_type;

   level_set_type level_queue[$];

   // shadow of the sound unit state
   logic [7:0]  regs [20];
   logic [7:0]  enable_bits, frame_ctl;
   logic [10:0] pl_timer [2], pl_period [2];
   logic [2:0]  pl_step [2];
   logic [7:0]  pl_len [2];
   logic [3:0]  env_vol [2], env_div [2], swp_div [2];
   logic        env_go [2], swp_go [2];
   logic [10:0] tr_timer;
   logic [4:0]  tr_step;
   logic [6:0]  tr_lin, tr_lin_load;
   logic        tr_load_flag;
   logic [7:0]  tr_len;
   logic [2:0]  seq_count;

   task automatic report_line(input string msg);
      $display("MISMATCH %s at %0t", msg, $realtime);
      fail_count++;
   endtask

   task automatic report_mismatch(input string what, input logic [3:0] got,
                                  input logic [3:0] want);
      report_line($sformatf("%s: got %0d, expected %0d", what, got, want));
   endtask

   task automatic clear_shadow();
      foreach (regs[i]) regs[i] = 8'h00;
      regs[0] = 8'h30; regs[4] = 8'h30; regs[12] = 8'h30;
      regs[1] = 8'h08; regs[5] = 8'h08; regs[8] = 8'h80;
      enable_bits = 0; frame_ctl = 0;
      for (int p = 0; p < 2; p++) begin
         pl_timer[p] = 0; pl_step[p] = 0; pl_period[p] = 0; pl_len[p] = 0;
         env_vol[p] = 0; env_div[p] = 0; env_go[p] = 1; swp_div[p] = 0; swp_go[p] = 1;
      end
      tr_timer = 0; tr_step = 0; tr_lin = 0; tr_lin_load = 0;
      tr_load_flag = 0; tr_len = 0; seq_count = 0;
   endtask

   function automatic logic [10:0] period_of(input int base);
      return {regs[base + 3][2:0], regs[base + 2]};
   endfunction

   function automatic logic [7:0] len_of(input logic [4:0] idx);
      logic [7:0] lut [32] = '{10,254,20,2,40,4,80,6,160,8,60,10,14,12,26,14,
                               12,16,24,18,48,20,96,22,192,24,72,26,16,28,32,30};
      return lut[idx];
   endfunction

   function automatic logic duty_bit(input logic [1:0] d, input logic [2:0] s);
      logic [7:0] pat [4] = '{8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001};
      return pat[d][s];
   endfunction

   task automatic pulse_advance(input int p, output logic [3:0] lvl);
      logic [7:0] r0;
      logic [3:0] vol;
      r0 = regs[p * 4];
      if (pl_timer[p] == 0) begin
         pl_timer[p] = pl_period[p];
         pl_step[p] = pl_step[p] + 3'd1;
      end else begin
         pl_timer[p] = pl_timer[p] - 11'd1;
      end
      vol = r0[4] ? r0[3:0] : env_vol[p];
      lvl = (duty_bit(r0[7:6], pl_step[p]) && pl_period[p] >= 8 && pl_len[p] != 0)
            ? vol : 4'd0;
   endtask

   task automatic triangle_advance(output logic [3:0] lvl);
      lvl = 0;
      if (tr_lin != 0 && tr_len != 0) begin
         if (tr_timer == 0) begin
            tr_timer = period_of(8);
            tr_step = tr_step + 5'd1;
         end else begin
            tr_timer = tr_timer - 11'd1;
         end
         lvl = tr_step[4] ? tr_step[3:0] : ~tr_step[3:0];
      end
   endtask

   task automatic envelope_step(input int p);
      logic [7:0] r0;
      r0 = regs[p * 4];
      if (env_go[p]) begin
         env_go[p] = 0; env_vol[p] = 4'hF; env_div[p] = r0[3:0];
      end else if (env_div[p] > 0) begin
         env_div[p]--;
      end else begin
         env_div[p] = r0[3:0];
         if (env_vol[p] > 0) env_vol[p]--;
         else if (r0[5]) env_vol[p] = 4'hF;
      end
      if (r0[4]) env_vol[p] = r0[3:0];
   endtask

   task automatic sweep_step(input int p);
      logic [7:0]  r1;
      logic [31:0] cur, tgt;
      r1 = regs[p * 4 + 1];
      if (swp_go[p]) begin
         swp_div[p] = {1'b0, r1[6:4]} + 4'd1; swp_go[p] = 0;
      end else if (swp_div[p] > 0) begin
         swp_div[p]--;
      end else begin
         swp_div[p] = {1'b0, r1[6:4]} + 4'd1;
         if (r1[7] && r1[2:0] != 0) begin
            cur = pl_period[p];
            if (r1[3]) tgt = cur - (cur >> r1[2:0]) - ((p == 0) ? 1 : 0);
            else tgt = cur + (cur >> r1[2:0]);
            tgt &= 32'hFFFF;
            if (tgt < 8 || tgt > PERIOD_MAX) pl_len[p] = 0;
            else pl_period[p] = tgt[10:0];
         end
      end
   endtask

   task automatic length_step();
      for (int p = 0; p < 2; p++)
         if (!regs[p * 4][5] && pl_len[p] > 0) pl_len[p]--;
      if (!regs[8][7] && tr_len > 0) tr_len--;
   endtask

   task automatic linear_step();
      if (tr_load_flag) tr_lin = tr_lin_load;
      else if (tr_lin > 0) tr_lin--;
      if (!regs[8][7]) tr_load_flag = 0;
   endtask

   task automatic register_write(input logic [4:0] off, input logic [7:0] v);
      int p;
      p = off >> 2;
      if (off < 8) begin
         regs[off] = v;
         case (off[1:0])
            2'd3: begin
               pl_len[p] = len_of(v[7:3]); env_go[p] = 1; pl_period[p] = period_of(p * 4);
            end
            2'd2: pl_period[p] = period_of(p * 4);
            2'd1: swp_go[p] = 1;
            default: ;
         endcase
      end else if (off < 5'h0C) begin
         regs[off] = v;
         if (off == 5'h08) begin
            tr_lin_load = v[6:0]; tr_load_flag = 1;
         end else if (off == 5'h0B) begin
            tr_len = len_of(v[7:3]); tr_load_flag = 1;
         end
      end else if (off < 5'h14) regs[off] = v;
      else if (off == 5'h14) regs[16] = v;
      else if (off == 5'h15) enable_bits = v;
      else if (off == 5'h17) frame_ctl = v;
   endtask

   task automatic sequencer_step();
      logic clk_half;
      if (!frame_ctl[7]) begin
         envelope_step(0); envelope_step(1); linear_step();
         clk_half = (seq_count == 1 || seq_count == 3);
         seq_count = 3'((seq_count + 1) % 4);
      end else begin
         if (seq_count != 3) begin
            envelope_step(0); envelope_step(1); linear_step();
         end
         clk_half = (seq_count == 1 || seq_count == 4);
         seq_count = 3'((seq_count + 1) % 5);
      end
      if (clk_half) begin
         length_step(); sweep_step(0); sweep_step(1);
      end
   endtask

   // predict on each request beat, compare on each result beat
   always @(posedge clock) begin
      level_set_type exp_lv, got;
      if (reset) begin
         clear_shadow();
         level_queue.delete();
         fail_count = 0;
         levels_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_pulse_one_level, rsp_pulse_two_level, rsp_triangle_level};
            levels_seen++;
            if (level_queue.size() == 0) begin
               report_line("unexpected result beat");
            end else begin
               exp_lv = level_queue.pop_front();
               if (got.p1 !== exp_lv.p1) report_mismatch("pulse one", got.p1, exp_lv.p1);
               if (got.p2 !== exp_lv.p2) report_mismatch("pulse two", got.p2, exp_lv.p2);
               if (got.tri_lvl !== exp_lv.tri_lvl)
                  report_mismatch("triangle", got.tri_lvl, exp_lv.tri_lvl);
            end
         end
         if (req_valid && req_ready) begin
            exp_lv = '0;
            case (action_type'(req_action))
               ACT_WRITE: register_write(req_reg_offset, req_write_data);
               ACT_TICK: begin
                  if (enable_bits[0]) pulse_advance(0, exp_lv.p1);
                  if (enable_bits[1]) pulse_advance(1, exp_lv.p2);
                  if (enable_bits[2]) triangle_advance(exp_lv.tri_lvl);
               end
               ACT_FRAME: sequencer_step();
               default: ;
            endcase
            level_queue.push_back(exp_lv);
         end
      end
      levels_pending = level_queue.size();
   end

endmodule

FILE: sim/console_apu_tone_channels_tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus, result stalls and the verdict.
module console_apu_tone_channels_tb;
   import apu_tone_pkg::*;

   logic       clock = 0, reset = 1;
   logic       req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   logic [1:0] req_action = ACT_NONE;
   logic [4:0] req_reg_offset = 0;
   logic [7:0] req_write_data = 0;
   logic [3:0] rsp_pulse_one_level, rsp_pulse_two_level, rsp_triangle_level;
   int         fail_count, levels_pending, levels_seen;
   int         cycle_count = 0, sent = 0;
   bit         hold_rsp = 0, calm = 0;

   localparam int CYCLE_LIMIT = 200000;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   console_apu_tone_channels uut (.*);
   apu_tone_checker chk (.*);

   // result side: random stall bursts, a long hold-off on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_ready <= 0;
         else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 3);
            repeat (n - 1) @(negedge clock);
         end else rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // one beat, with optional idle burst ahead of it
   task automatic send_beat(input action_type a, input logic [4:0] off, input logic [7:0] v);
      int n;
      if (!calm && $urandom_range(0, 6) == 0) begin
         req_valid <= 0;
         n = $urandom_range(1, 3);
         repeat (n) @(negedge clock);
      end
      req_valid <= 1; req_action <= a; req_reg_offset <= off; req_write_data <= v;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic wr(input logic [4:0] off, input logic [7:0] v);
      send_beat(ACT_WRITE, off, v);
   endtask

   // a well-formed voice setup with random content
   task automatic setup_voices();
      wr(5'h15, 8'h07 | 8'($urandom_range(0, 255)) & 8'hF8);
      wr(5'h17, $urandom_range(0, 1) ? 8'h80 : 8'h00);
      for (int p = 0; p < 2; p++) begin
         wr(5'(p * 4), 8'($urandom_range(0, 255)));
         wr(5'(p * 4 + 1), 8'($urandom_range(0, 255)));
         wr(5'(p * 4 + 2), 8'($urandom_range(0, 255)));
         wr(5'(p * 4 + 3), 8'($urandom_range(0, 255)));
      end
      wr(5'h08, 8'($urandom_range(0, 255)));
      wr(5'h0A, 8'($urandom_range(0, 31)));
      wr(5'h0B, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int k;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, every action, unmapped offsets, short periods
      wr(5'h15, 8'hFF);
      wr(5'h00, 8'hFF); wr(5'h01, 8'hFF); wr(5'h02, 8'h03); wr(5'h03, 8'hF8);
      wr(5'h04, 8'h80); wr(5'h05, 8'h88); wr(5'h06, 8'hFF); wr(5'h07, 8'h07);
      wr(5'h08, 8'h7F); wr(5'h0A, 8'h00); wr(5'h0B, 8'hFF);
      wr(5'h14, 8'hAA); wr(5'h16, 8'h55); wr(5'h1F, 8'hFF); wr(5'h17, 8'h80);
      for (int i = 0; i < 6; i++) send_beat(ACT_FRAME, 0, 0);
      send_beat(ACT_NONE, 5'h1F, 8'hFF);
      for (int i = 0; i < 4; i++) send_beat(ACT_TICK, 0, 0);

      // random: occasional setup then tick/frame runs, some noise
      while (sent < 950) begin
         if (sent > 800) calm = 1;
         if ($urandom_range(0, 3) == 0) setup_voices();
         k = $urandom_range(10, 40);
         for (int i = 0; i < k; i++) begin
            case ($urandom_range(0, 9))
               0: send_beat(action_type'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                            8'($urandom_range(0, 255)));
               1, 2, 3: send_beat(ACT_FRAME, 5'($urandom_range(0, 31)),
                                  8'($urandom_range(0, 255)));
               default: send_beat(ACT_TICK, 5'($urandom_range(0, 31)),
                                  8'($urandom_range(0, 255)));
            endcase
         end
         // long hold-off on the result side while requests keep coming
         if (sent > 300 && sent < 360) begin
            hold_rsp = 1;
            fork
               begin repeat (40) @(posedge clock); hold_rsp = 0; end
               for (int i = 0; i < 12; i++) send_beat(ACT_TICK, 0, 0);
            join
         end
         // sender pause until all results are in
         if (sent > 600 && sent < 660) begin
            req_valid <= 0;
            while (levels_pending != 0) @(negedge clock);
         end
      end
      req_valid <= 0;
      while (levels_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("Ran %0d request beats and checked %0d result beats:", sent, levels_seen);
      $display("register writes, timer ticks, 4- and 5-step frame sequencing, stalls.");
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/apu_tone_pkg.sv
rtl/apu_tone_pulse.sv
rtl/apu_tone_triangle.sv
rtl/console_apu_tone_channels.sv
sim/apu_tone_checker.sv
sim/console_apu_tone_channels_tb.sv
